// ===== rtl/oas_pkg.sv =====
// ----------------------------------------------------------------------------
// oas_pkg
// Shared types, register indexes and reset values for the obstacle
// avoidance sequencer.
// ----------------------------------------------------------------------------
package oas_pkg;

	localparam int unsigned CNT_W   = 16;
	localparam int unsigned LIM_W   = 15;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 15;
	localparam int unsigned SIDES   = 3;

	typedef enum logic [1:0] {
		MODE_STOP   = 2'd0,
		MODE_ACTION = 2'd1,
		MODE_NORMAL = 2'd2,
		MODE_OTHER  = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ENABLE      = 3'd0,
		REG_SIDE_MASK   = 3'd1,
		REG_MODE        = 3'd2,
		REG_DIRECTION   = 3'd3,
		REG_ACTIVE_LVLS = 3'd4,
		REG_STOP_HOLD   = 3'd5,
		REG_ACTION_WAIT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic             enable;
		logic [SIDES-1:0] side_mask;
		mode_t            mode;
		logic             direction;
		logic [2*SIDES-1:0] active_levels;
		logic [LIM_W-1:0] stop_hold_ticks;
		logic [LIM_W-1:0] action_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic             detect_flag;
		logic [CNT_W-1:0] tick_count;
		logic             avoid_in_progress;
	} seq_state_t;

	typedef struct packed {
		logic brake_cmd;
		logic release_cmd;
		logic end_move_cmd;
		logic detecting;
	} result_t;

	localparam logic [LIM_W-1:0] STOP_HOLD_RST   = 15'd20;
	localparam logic [LIM_W-1:0] ACTION_WAIT_RST = 15'd100;

	localparam cfg_t CFG_RST = '{
		enable:            1'b1,
		side_mask:         3'b111,
		mode:              MODE_NORMAL,
		direction:         1'b0,
		active_levels:     6'd0,
		stop_hold_ticks:   STOP_HOLD_RST,
		action_wait_ticks: ACTION_WAIT_RST
	};

	localparam seq_state_t STATE_RST = '{
		detect_flag:       1'b0,
		tick_count:        16'd0,
		avoid_in_progress: 1'b0
	};

endpackage

// ===== rtl/oas_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// oas_cfg_regs
// Configuration register file, one write per cycle, always ready.
// ----------------------------------------------------------------------------
module oas_cfg_regs
	import oas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_ENABLE:      cfg_q.enable            <= wr_data[0];
				REG_SIDE_MASK:   cfg_q.side_mask         <= wr_data[SIDES-1:0];
				REG_MODE:        cfg_q.mode              <= mode_t'(wr_data[1:0]);
				REG_DIRECTION:   cfg_q.direction         <= wr_data[0];
				REG_ACTIVE_LVLS: cfg_q.active_levels     <= wr_data[2*SIDES-1:0];
				REG_STOP_HOLD:   cfg_q.stop_hold_ticks   <= wr_data[LIM_W-1:0];
				REG_ACTION_WAIT: cfg_q.action_wait_ticks <= wr_data[LIM_W-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/oas_hit.sv =====
// ----------------------------------------------------------------------------
// oas_hit
// Obstacle hit detection: compare raw levels against active levels for
// the selected side, masked by the enabled sensors.
// ----------------------------------------------------------------------------
module oas_hit
	import oas_pkg::*;
(
	input  logic [SIDES-1:0]   front_levels,
	input  logic [SIDES-1:0]   rear_levels,
	input  logic               direction,
	input  logic [SIDES-1:0]   side_mask,
	input  logic [2*SIDES-1:0] active_levels,
	output logic               hit
);

	logic [SIDES-1:0] lv;
	logic [SIDES-1:0] act;

	always_comb begin
		if (direction) begin
			lv  = rear_levels;
			act = active_levels[2*SIDES-1:SIDES];
		end else begin
			lv  = front_levels;
			act = active_levels[SIDES-1:0];
		end
		hit = |(~(lv ^ act) & side_mask);
	end

endmodule

// ===== rtl/oas_step.sv =====
// ----------------------------------------------------------------------------
// oas_step
// Next-state and command logic of the sequencer for one tick.
// ----------------------------------------------------------------------------
module oas_step
	import oas_pkg::*;
(
	input  cfg_t       cfg,
	input  seq_state_t cur,
	input  logic       hit,
	output seq_state_t nxt,
	output result_t    res
);

	logic [CNT_W-1:0] cnt_inc;

	assign cnt_inc = cur.tick_count + CNT_W'(1);

	always_comb begin
		nxt              = cur;
		res.brake_cmd    = 1'b0;
		res.release_cmd  = 1'b0;
		res.end_move_cmd = 1'b0;
		if (cfg.enable) begin
			if (hit && !cur.detect_flag) begin
				nxt.tick_count        = '0;
				nxt.avoid_in_progress = 1'b0;
				nxt.detect_flag       = 1'b1;
				res.brake_cmd         = 1'b1;
			end else if (cur.detect_flag && cfg.mode == MODE_STOP) begin
				nxt.tick_count = cnt_inc;
				if (cnt_inc > {1'b0, cfg.stop_hold_ticks}) begin
					if (!hit) begin
						nxt.tick_count  = {1'b0, cfg.stop_hold_ticks};
						nxt.detect_flag = 1'b0;
						res.release_cmd = 1'b1;
					end else begin
						nxt.tick_count = '0;
					end
				end
			end else if (cur.detect_flag &&
					(cfg.mode == MODE_ACTION || cfg.mode == MODE_NORMAL)) begin
				if (!cur.avoid_in_progress) begin
					nxt.tick_count = cnt_inc;
					if (cnt_inc > {1'b0, cfg.action_wait_ticks}) begin
						nxt.tick_count  = '0;
						nxt.detect_flag = 1'b0;
						if (hit) begin
							nxt.avoid_in_progress = 1'b1;
							res.end_move_cmd      = 1'b1;
						end else begin
							res.release_cmd = 1'b1;
						end
					end
				end
			end else if (cur.detect_flag) begin
				nxt.detect_flag = 1'b0;
				res.release_cmd = 1'b1;
			end
		end
		res.detecting = nxt.detect_flag;
	end

endmodule

// ===== rtl/obstacle_avoidance_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoidance_sequencer_unit
// Path: an accepted word is registered in the input stage, then moves
// into the result register, which drives out_valid and the commands.
// Throughput: one tick word per cycle unless out_ready stalls the result stage.
// Reset: configuration returns to its defaults, detection state and all
// valid flags clear; the first word may be taken right after reset.
// ----------------------------------------------------------------------------
module obstacle_avoidance_sequencer_unit
	import oas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// tick input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SIDES-1:0]  front_levels,
	input  logic [SIDES-1:0]  rear_levels,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              brake_cmd,
	output logic              release_cmd,
	output logic              end_move_cmd,
	output logic              detecting,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	cfg_t             cfg;
	seq_state_t       state_q;
	seq_state_t       state_nxt;
	result_t          res_nxt;
	result_t          res_q;
	logic             hit;

	// input stage
	logic             valid_s1;
	logic [SIDES-1:0] front_s1;
	logic [SIDES-1:0] rear_s1;

	logic             out_valid_q;
	logic             advance;

	// Always writable; config must be changed only while idle (unenforced).
	assign cfg_ready = 1'b1;

	oas_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the input word into the result register when the result slot is
	// free or being drained this cycle. The state advances on the same edge,
	// so consecutive words see each other's updates in order.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the input stage: no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			front_s1 <= front_levels;
			rear_s1  <= rear_levels;
		end
	end

	oas_hit u_hit (
		.front_levels  (front_s1),
		.rear_levels   (rear_s1),
		.direction     (cfg.direction),
		.side_mask     (cfg.side_mask),
		.active_levels (cfg.active_levels),
		.hit           (hit)
	);

	oas_step u_step (
		.cfg (cfg),
		.cur (state_q),
		.hit (hit),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// Sequencer state: commit only when the word is handed to the result
	// register, so a stalled output never double-counts a tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign brake_cmd    = res_q.brake_cmd;
	assign release_cmd  = res_q.release_cmd;
	assign end_move_cmd = res_q.end_move_cmd;
	assign detecting    = res_q.detecting;

	// A brake always starts detection.
	a_brake_detects: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brake_cmd |-> detecting)
		else $error("brake without detecting");

	// Release or end of move always ends detection.
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (release_cmd || end_move_cmd) |-> !detecting)
		else $error("release or end move while still detecting");

	// An abandoned move is only flagged once detection has ended.
	a_avoid_not_detect: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.avoid_in_progress |-> !state_q.detect_flag)
		else $error("avoid in progress while detecting");

	// State only changes when a word passes into the result register.
	a_state_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("sequencer state changed without a word");

endmodule

// ===== verif/obstacle_avoidance_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoidance_sequencer_unit_tb
// Self-checking bench for the obstacle avoidance sequencer. It opens with a
// short directed sequence: every mode, disabled ticks, hits while already
// detecting, and the hold and wait expiries. After that it runs register
// setups chosen at random, each with a stream of obstacle and clear ticks.
// A scoreboard predicts the command word for every accepted tick and
// compares each result field by field.
// ----------------------------------------------------------------------------
module obstacle_avoidance_sequencer_unit_tb;
	import oas_pkg::*;

	// Scoreboard: its own copy of the registers and detection state. It
	// predicts one command word per accepted tick and checks results in order.
	class tick_scoreboard;
		cfg_t        cfg;
		seq_state_t  st;
		result_t     pending_cmds[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned n_brake;
		int unsigned n_release;
		int unsigned n_end_move;

		function new();
			cfg        = CFG_RST;
			st         = STATE_RST;
			errors     = 0;
			checked    = 0;
			n_brake    = 0;
			n_release  = 0;
			n_end_move = 0;
		endfunction

		task report(input string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			errors++;
		endtask

		function void set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
			case (idx)
				REG_ENABLE:      cfg.enable            = val[0];
				REG_SIDE_MASK:   cfg.side_mask         = val[SIDES-1:0];
				REG_MODE:        cfg.mode              = mode_t'(val[1:0]);
				REG_DIRECTION:   cfg.direction         = val[0];
				REG_ACTIVE_LVLS: cfg.active_levels     = val[2*SIDES-1:0];
				REG_STOP_HOLD:   cfg.stop_hold_ticks   = val[LIM_W-1:0];
				REG_ACTION_WAIT: cfg.action_wait_ticks = val[LIM_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the detection state by one tick and return its command word.
		function result_t predict_tick(input logic [SIDES-1:0] front,
				input logic [SIDES-1:0] rear);
			logic [SIDES-1:0] lv;
			logic [SIDES-1:0] act;
			logic [SIDES-1:0] match;
			logic             hit;
			result_t          res;
			res = '0;
			if (cfg.enable) begin
				if (cfg.direction) begin
					lv  = rear;
					act = cfg.active_levels[2*SIDES-1:SIDES];
				end else begin
					lv  = front;
					act = cfg.active_levels[SIDES-1:0];
				end
				match = ~(lv ^ act) & cfg.side_mask;
				hit   = |match;
				if (hit && !st.detect_flag) begin
					st.tick_count        = '0;
					st.avoid_in_progress = 1'b0;
					st.detect_flag       = 1'b1;
					res.brake_cmd        = 1'b1;
				end else if (st.detect_flag && cfg.mode == MODE_STOP) begin
					st.tick_count = st.tick_count + CNT_W'(1);
					if (st.tick_count > {1'b0, cfg.stop_hold_ticks}) begin
						st.tick_count = {1'b0, cfg.stop_hold_ticks};
						if (!hit) begin
							st.detect_flag  = 1'b0;
							res.release_cmd = 1'b1;
						end else begin
							st.tick_count = '0;
						end
					end
				end else if (st.detect_flag &&
						(cfg.mode == MODE_ACTION || cfg.mode == MODE_NORMAL)) begin
					if (!st.avoid_in_progress) begin
						st.tick_count = st.tick_count + CNT_W'(1);
						if (st.tick_count > {1'b0, cfg.action_wait_ticks}) begin
							st.tick_count  = '0;
							st.detect_flag = 1'b0;
							if (hit) begin
								st.avoid_in_progress = 1'b1;
								res.end_move_cmd     = 1'b1;
							end else begin
								res.release_cmd = 1'b1;
							end
						end
					end
				end else if (st.detect_flag) begin
					st.detect_flag  = 1'b0;
					res.release_cmd = 1'b1;
				end
			end
			res.detecting = st.detect_flag;
			return res;
		endfunction

		function void note_tick(input logic [SIDES-1:0] front,
				input logic [SIDES-1:0] rear);
			pending_cmds.push_back(predict_tick(front, rear));
		endfunction

		task check_result(input result_t got);
			result_t want;
			if (pending_cmds.size() == 0) begin
				report($sformatf("result %b with no tick outstanding", got));
			end else begin
				want = pending_cmds.pop_front();
				if (got.brake_cmd !== want.brake_cmd)
					report($sformatf("result %0d brake_cmd %b, want %b",
						checked, got.brake_cmd, want.brake_cmd));
				if (got.release_cmd !== want.release_cmd)
					report($sformatf("result %0d release_cmd %b, want %b",
						checked, got.release_cmd, want.release_cmd));
				if (got.end_move_cmd !== want.end_move_cmd)
					report($sformatf("result %0d end_move_cmd %b, want %b",
						checked, got.end_move_cmd, want.end_move_cmd));
				if (got.detecting !== want.detecting)
					report($sformatf("result %0d detecting %b, want %b",
						checked, got.detecting, want.detecting));
				n_brake    += 32'(want.brake_cmd);
				n_release  += 32'(want.release_cmd);
				n_end_move += 32'(want.end_move_cmd);
			end
			checked++;
		endtask
	endclass

	localparam int unsigned RANDOM_TICKS = 1100;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [SIDES-1:0]  front_levels;
	logic [SIDES-1:0]  rear_levels;
	logic              out_valid;
	logic              out_ready;
	logic              brake_cmd;
	logic              release_cmd;
	logic              end_move_cmd;
	logic              detecting;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;

	tick_scoreboard sb = new();

	obstacle_avoidance_sequencer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.front_levels (front_levels),
		.rear_levels  (rear_levels),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.brake_cmd    (brake_cmd),
		.release_cmd  (release_cmd),
		.end_move_cmd (end_move_cmd),
		.detecting    (detecting),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Present one tick word and hold it until the block takes it. Valid is
	// left high on return; the caller drops it when a gap is wanted. Enter
	// and leave on a rising edge.
	task automatic send_tick(input logic [SIDES-1:0] front, input logic [SIDES-1:0] rear);
		in_valid     <= 1'b1;
		front_levels <= front;
		rear_levels  <= rear;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_tick(front, rear);
	endtask

	// Write one register. Valid stays high so back-to-back writes never
	// drop and raise it in the same step; the caller lowers it after a batch.
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Hold off the tick channel until every predicted word has come back.
	// Every tick yields a result, so an empty queue means the block is idle.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (sb.pending_cmds.size() != 0) @(posedge clk);
	endtask

	// Mostly short limits so that expiries happen often; now and then the
	// extremes or a middling value.
	function automatic logic [DATA_W-1:0] pick_limit();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return {DATA_W{1'b1}};
			2, 3:    return DATA_W'($urandom_range(10, 40));
			default: return DATA_W'($urandom_range(0, 6));
		endcase
	endfunction

	// Result side: check every accepted word, then pick the next ready. The
	// stall pattern is redrawn at regular intervals among always ready, sparse
	// random stalls, a fixed repeating stall pattern and a coin toss.
	initial begin : result_sink
		int unsigned rx_cycle;
		int unsigned stall_style;
		result_t     got;
		rx_cycle    = 0;
		stall_style = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {brake_cmd, release_cmd, end_move_cmd, detecting};
				sb.check_result(got);
			end
			rx_cycle++;
			if (rx_cycle % 150 == 0)
				stall_style = $urandom_range(0, 3);
			case (stall_style)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				2:       out_ready <= (rx_cycle % 7) >= 3;
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Main stimulus: reset, directed ticks, then random setups.
	initial begin : stimulus
		int unsigned       ticks_sent;
		int unsigned       setups;
		int unsigned       phase_len;
		int unsigned       burst_left;
		int unsigned       gap;
		bit                obstacle_on;
		logic [SIDES-1:0]  act;
		logic [SIDES-1:0]  watched;
		logic [SIDES-1:0]  flip;
		logic [SIDES-1:0]  other;
		logic [DATA_W-1:0] val;

		ticks_sent  = 0;
		setups      = 0;
		burst_left  = 0;
		obstacle_on = 1'b0;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		front_levels <= '0;
		rear_levels  <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setup (normal mode, active level 0, all sides): a clear
		// tick, a new obstacle, then hits while already detecting.
		send_tick(3'd7, 3'd0);
		send_tick(3'd0, 3'd7);
		send_tick(3'd0, 3'd7);
		send_tick(3'd3, 3'd5);

		// Disabled: ticks are ignored, detecting still shows the flag.
		wait_all_results();
		write_reg(REG_ENABLE, 15'h7ffe);
		cfg_valid <= 1'b0;
		send_tick(3'd0, 3'd0);
		send_tick(3'd7, 3'd7);

		// Action mode with zero wait: an obstacle that stays ends the move,
		// then a fresh brake and a clear tick release.
		wait_all_results();
		write_reg(REG_ENABLE, 15'd1);
		write_reg(REG_ACTION_WAIT, 15'd0);
		write_reg(REG_MODE, DATA_W'(MODE_ACTION));
		cfg_valid <= 1'b0;
		send_tick(3'd0, 3'd0);
		send_tick(3'd7, 3'd7);
		send_tick(3'd0, 3'd0);
		send_tick(3'd7, 3'd7);

		// Stop mode, hold of one: a hit at expiry restarts the count, a
		// clear path at expiry releases.
		wait_all_results();
		write_reg(REG_MODE, DATA_W'(MODE_STOP));
		write_reg(REG_STOP_HOLD, 15'd1);
		cfg_valid <= 1'b0;
		send_tick(3'd0, 3'd0);
		send_tick(3'd0, 3'd0);
		send_tick(3'd0, 3'd0);
		send_tick(3'd7, 3'd7);
		send_tick(3'd7, 3'd7);

		// Other mode: brake, then release on the next tick.
		wait_all_results();
		write_reg(REG_MODE, DATA_W'(MODE_OTHER));
		cfg_valid <= 1'b0;
		send_tick(3'd6, 3'd0);
		send_tick(3'd5, 3'd0);

		// Backward, all levels active high, center only, normal mode.
		wait_all_results();
		write_reg(REG_DIRECTION, 15'd1);
		write_reg(REG_ACTIVE_LVLS, 15'd63);
		write_reg(REG_SIDE_MASK, 15'd2);
		write_reg(REG_MODE, DATA_W'(MODE_NORMAL));
		write_reg(REG_ACTION_WAIT, 15'd1);
		cfg_valid <= 1'b0;
		send_tick(3'd0, 3'd2);
		send_tick(3'd0, 3'd0);
		send_tick(3'd0, 3'd0);
		// No side enabled: nothing can ever be a hit.
		wait_all_results();
		write_reg(REG_SIDE_MASK, 15'd0);
		cfg_valid <= 1'b0;
		send_tick(3'd0, 3'd7);
		send_tick(3'd7, 3'd7);

		// Random part: each phase drains, rewrites every register, then
		// streams ticks in bursts. Obstacles come and go in runs so that
		// the hold and wait timers expire with either outcome.
		while (ticks_sent < RANDOM_TICKS) begin
			wait_all_results();
			setups++;
			val    = DATA_W'($urandom);
			val[0] = ($urandom_range(0, 7) != 0);
			write_reg(REG_ENABLE, val);
			case ($urandom_range(0, 4))
				0:       val = 15'd0;
				1:       val = 15'd7;
				default: val = DATA_W'($urandom);
			endcase
			write_reg(REG_SIDE_MASK, val);
			write_reg(REG_MODE, DATA_W'($urandom));
			write_reg(REG_DIRECTION, DATA_W'($urandom));
			case ($urandom_range(0, 4))
				0:       val = 15'd0;
				1:       val = 15'd63;
				default: val = DATA_W'($urandom);
			endcase
			write_reg(REG_ACTIVE_LVLS, val);
			write_reg(REG_STOP_HOLD, pick_limit());
			write_reg(REG_ACTION_WAIT, pick_limit());
			cfg_valid <= 1'b0;

			phase_len = $urandom_range(30, 110);
			repeat (phase_len) begin
				// Drop valid for a random gap between bursts; a zero gap
				// keeps the stream going without a hole.
				if (burst_left == 0) begin
					gap = $urandom_range(0, 4);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;

				if ($urandom_range(0, 4) == 0) begin
					// Noise: levels with no shaping at all.
					send_tick(SIDES'($urandom), SIDES'($urandom));
				end else begin
					if ($urandom_range(0, 4) == 0)
						obstacle_on = !obstacle_on;
					act = sb.cfg.direction ? sb.cfg.active_levels[2*SIDES-1:SIDES]
						: sb.cfg.active_levels[SIDES-1:0];
					// Start from a clear path on the watched side, then match
					// at least one enabled sensor for an obstacle.
					watched = ~act;
					if (obstacle_on) begin
						flip = SIDES'($urandom_range(1, 7)) & sb.cfg.side_mask;
						if (flip == 0)
							flip = sb.cfg.side_mask;
						watched = watched ^ flip;
					end
					watched = watched ^ (SIDES'($urandom) & ~sb.cfg.side_mask);
					other   = SIDES'($urandom);
					if (sb.cfg.direction)
						send_tick(other, watched);
					else
						send_tick(watched, other);
				end
				ticks_sent++;
			end
		end

		// Drain, then let the clock run on so that any stray word would show.
		wait_all_results();
		repeat (8) @(posedge clk);

		$display("Covered %0d ticks over %0d random register setups after the directed set.",
			sb.checked, setups);
		$display("Results checked: %0d brake, %0d release, %0d end-move commands.",
			sb.n_brake, sb.n_release, sb.n_end_move);
		if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin : watchdog
		#2_000_000;
		$display("Timeout: %0d results still outstanding", sb.pending_cmds.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
